// File: rtl/tgm_pkg.sv
package tgm_pkg;

  typedef enum logic [1:0] {
    OpUpdate  = 2'd0,
    OpRelease = 2'd1,
    OpTick    = 2'd2
  } op_e;

  localparam logic [1:0] RegDeadzone  = 2'd0;
  localparam logic [1:0] RegGain      = 2'd1;
  localparam logic [1:0] RegDoubleTap = 2'd2;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DeltaW = CoordW + 1;
  localparam int unsigned MoveW  = 21;

  localparam logic [15:0] TapMax = 16'hFFFF;

  typedef struct packed {
    logic                     move_valid;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     press_left;
    logic                     press_right;
    logic                     release_buttons;
  } cmd_t;

endpackage

// File: rtl/tgm_front.sv
module tgm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          operation_i,
  input  logic [15:0]         finger_id_i,
  input  logic [11:0]         finger_x_i,
  input  logic [11:0]         finger_y_i,
  input  logic [3:0]          finger_count_i,
  input  logic [7:0]          deadzone_radius_i,
  input  logic [15:0]         double_tap_ticks_i,
  output logic                cmd_push_o,
  output tgm_pkg::cmd_t       cmd_o
);
  import tgm_pkg::*;

  logic              trk_valid_q, trk_valid_d;
  logic [15:0]       trk_id_q, trk_id_d;
  logic [11:0]       trk_x_q, trk_x_d;
  logic [11:0]       trk_y_q, trk_y_d;
  logic              moved_q, moved_d;
  logic [3:0]        prior_q, prior_d;
  logic [15:0]       tap_q, tap_d;

  logic                     match;
  logic signed [DeltaW-1:0] dx, dy;
  logic [2*DeltaW-1:0]      dx_sq, dy_sq;
  logic [2*DeltaW:0]        dist_sq;
  logic [15:0]              rad_sq;
  logic                     moving;
  logic                     emit;
  cmd_t                     cmd;

  assign match   = trk_valid_q && (trk_id_q == finger_id_i);
  assign dx      = $signed({1'b0, finger_x_i}) - $signed({1'b0, trk_x_q});
  assign dy      = $signed({1'b0, finger_y_i}) - $signed({1'b0, trk_y_q});
  assign dx_sq   = $unsigned((2*DeltaW)'(dx) * (2*DeltaW)'(dx));
  assign dy_sq   = $unsigned((2*DeltaW)'(dy) * (2*DeltaW)'(dy));
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign rad_sq  = 16'(deadzone_radius_i) * 16'(deadzone_radius_i);
  assign moving  = dist_sq > {{(2*DeltaW-15){1'b0}}, rad_sq};

  always_comb begin
    trk_valid_d = trk_valid_q;
    trk_id_d    = trk_id_q;
    trk_x_d     = trk_x_q;
    trk_y_d     = trk_y_q;
    moved_d     = moved_q;
    prior_d     = prior_q;
    tap_d       = tap_q;
    emit        = 1'b0;
    cmd         = '0;
    unique case (operation_i)
      OpUpdate: begin
        prior_d = finger_count_i;
        if (match) begin
          emit           = 1'b1;
          cmd.move_valid = 1'b1;
          if (moving) begin
            cmd.press_left = (tap_q <= double_tap_ticks_i);
            cmd.dx         = dx;
            cmd.dy         = dy;
            trk_x_d        = finger_x_i;
            trk_y_d        = finger_y_i;
            moved_d        = 1'b1;
          end
        end else begin
          trk_valid_d = 1'b1;
          trk_id_d    = finger_id_i;
          trk_x_d     = finger_x_i;
          trk_y_d     = finger_y_i;
        end
      end
      OpRelease: begin
        trk_valid_d = 1'b0;
        unique case (prior_q)
          4'd0: begin
            emit                = 1'b1;
            cmd.release_buttons = 1'b1;
            moved_d             = 1'b0;
          end
          4'd1: begin
            tap_d          = '0;
            emit           = !moved_q;
            cmd.press_left = !moved_q;
            prior_d        = '0;
          end
          4'd2: begin
            emit            = !moved_q;
            cmd.press_right = !moved_q;
            prior_d         = '0;
          end
          default: ;
        endcase
      end
      OpTick: begin
        if (tap_q != TapMax) tap_d = tap_q + 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_valid_q <= 1'b0;
      trk_id_q    <= '0;
      trk_x_q     <= '0;
      trk_y_q     <= '0;
      moved_q     <= 1'b0;
      prior_q     <= '0;
      tap_q       <= '0;
    end else if (accept_i) begin
      trk_valid_q <= trk_valid_d;
      trk_id_q    <= trk_id_d;
      trk_x_q     <= trk_x_d;
      trk_y_q     <= trk_y_d;
      moved_q     <= moved_d;
      prior_q     <= prior_d;
      tap_q       <= tap_d;
    end
  end

  assign cmd_push_o = accept_i && emit;
  assign cmd_o      = cmd;

endmodule

// File: rtl/tgm_queue.sv
module tgm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tgm_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tgm_pkg::cmd_t rdata_o
);
  import tgm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    if (do_pop)  rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// File: rtl/tgm_back.sv
module tgm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_avail_i,
  input  tgm_pkg::cmd_t       cmd_i,
  output logic                cmd_take_o,
  input  logic [15:0]         move_gain_i,
  output logic                out_empty_o,
  input  logic                out_pop_i,
  output logic                move_valid_o,
  output logic signed [20:0]  move_dx_o,
  output logic signed [20:0]  move_dy_o,
  output logic                press_left_o,
  output logic                press_right_o,
  output logic                release_buttons_o
);
  import tgm_pkg::*;

  localparam int unsigned ProdW = DeltaW + 16;

  logic              out_vld_q;
  logic              take;
  logic [MoveW-1:0]  sx_d, sy_d;
  logic [MoveW-1:0]  sx_q, sy_q;
  cmd_t              cmd_q;

  function automatic logic [MoveW-1:0] scale(input logic signed [DeltaW-1:0] d,
                                             input logic [15:0] gain);
    logic [DeltaW-1:0] mag;
    logic [ProdW-1:0]  prod;
    logic [MoveW-1:0]  p;
    mag  = d[DeltaW-1] ? DeltaW'(-d) : DeltaW'(d);
    prod = mag * gain;
    p    = prod[MoveW+7:8];
    return d[DeltaW-1] ? MoveW'(-p) : p;
  endfunction

  assign take       = cmd_avail_i && (!out_vld_q || out_pop_i);
  assign cmd_take_o = take;
  assign sx_d       = scale(cmd_i.dx, move_gain_i);
  assign sy_d       = scale(cmd_i.dy, move_gain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b1;
    end else if (out_pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
    end
  end

  assign out_empty_o       = !out_vld_q;
  assign move_valid_o      = cmd_q.move_valid;
  assign move_dx_o         = $signed(sx_q);
  assign move_dy_o         = $signed(sy_q);
  assign press_left_o      = cmd_q.press_left;
  assign press_right_o     = cmd_q.press_right;
  assign release_buttons_o = cmd_q.release_buttons;

endmodule

// File: rtl/touch_gesture_to_mouse.sv
// channel   direction  handshake            word
// events    in         push / full          operation, finger_id, finger_x, finger_y, finger_count
// actions   out        empty / pop          move_valid, move_dx, move_dy, press_left/right, release
// config    in         cfg_we (no wait)     cfg_idx selects register, cfg_wdata
//
// one event is accepted per cycle while full is low; the front updates gesture state in the
// cycle it accepts, so an event's effect is seen by the next event at once
// an action word reaches the outputs through the command queue and then the output
// register, which holds the result of the gain multiply
// full follows the command queue, which fills only while pop is held low
// reset clears gesture state and loads deadzone 10, gain 1.0, drag window 200 ticks
module touch_gesture_to_mouse #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        finger_id_i,
  input  logic [11:0]        finger_x_i,
  input  logic [11:0]        finger_y_i,
  input  logic [3:0]         finger_count_i,
  output logic               empty,
  input  logic               pop,
  output logic               move_valid_o,
  output logic signed [20:0] move_dx_o,
  output logic signed [20:0] move_dy_o,
  output logic               press_left_o,
  output logic               press_right_o,
  output logic               release_buttons_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import tgm_pkg::*;

  logic [7:0]  radius_q;
  logic [15:0] gain_q;
  logic [15:0] dtap_q;

  logic  accept;
  logic  cmd_push;
  cmd_t  cmd_w;
  cmd_t  cmd_r;
  logic  q_empty;
  logic  q_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 8'd10;
      gain_q   <= 16'd256;
      dtap_q   <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDeadzone:  radius_q <= cfg_wdata_i[7:0];
        RegGain:      gain_q   <= cfg_wdata_i;
        RegDoubleTap: dtap_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  tgm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .operation_i        (operation_i),
    .finger_id_i        (finger_id_i),
    .finger_x_i         (finger_x_i),
    .finger_y_i         (finger_y_i),
    .finger_count_i     (finger_count_i),
    .deadzone_radius_i  (radius_q),
    .double_tap_ticks_i (dtap_q),
    .cmd_push_o         (cmd_push),
    .cmd_o              (cmd_w)
  );

  tgm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_w),
    .full_o  (full),
    .pop_i   (q_take),
    .empty_o (q_empty),
    .rdata_o (cmd_r)
  );

  tgm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_avail_i       (!q_empty),
    .cmd_i             (cmd_r),
    .cmd_take_o        (q_take),
    .move_gain_i       (gain_q),
    .out_empty_o       (empty),
    .out_pop_i         (pop),
    .move_valid_o      (move_valid_o),
    .move_dx_o         (move_dx_o),
    .move_dy_o         (move_dy_o),
    .press_left_o      (press_left_o),
    .press_right_o     (press_right_o),
    .release_buttons_o (release_buttons_o)
  );

  // at most one of move, right press and release per word
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $onehot0({move_valid_o, press_right_o, release_buttons_o}))
    else $error("action word carries more than one kind");

  // left press only alone or with a move
  a_left_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && press_left_o) |-> (!press_right_o && !release_buttons_o))
    else $error("left press mixed with another button action");

  // a queued command reaches an empty output register next cycle
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty && empty) |=> !empty)
    else $error("queued command not moved to output");

endmodule
